// ===== rtl/core/u8td_pkg.sv =====
// u8td_pkg: words, direction codes and the utf-8 step decoder for the text direction scanner
// no dependencies; used by u8td_decode and utf8_text_direction_scan

package u8td_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int TOTAL_BITS     = 32;
	localparam int WIN_BYTES      = 4;
	localparam int HELD_BYTES     = 3;

	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
	localparam logic [7:0]  LEAD2_LO     = 8'hC2;
	localparam logic [7:0]  LEAD2_HI     = 8'hDF;
	localparam logic [7:0]  LEAD3_LO     = 8'hE0;
	localparam logic [7:0]  LEAD3_HI     = 8'hEF;
	localparam logic [7:0]  LEAD4_LO     = 8'hF0;
	localparam logic [7:0]  LEAD4_HI     = 8'hF4;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_LTR  = 2'd1,
		DIR_RTL  = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		OVR_LTR   = 2'd0,
		OVR_RTL   = 2'd1,
		OVR_MIXED = 2'd2
	} ovr_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} text_word_t;

	typedef struct packed {
		logic [1:0]            overall_direction;
		logic [1:0]            first_strong_dir;
		logic                  rtl_majority;
		logic                  ltr_majority;
		logic [TOTAL_BITS-1:0] ltr_total;
		logic [TOTAL_BITS-1:0] rtl_total;
	} scan_word_t;

	typedef struct packed {
		logic       emit;
		dir_t       dir;
		logic [2:0] drop;
		logic       stop;
	} step_t;

	typedef struct packed {
		logic [2:0]                  ltr_inc;
		logic [2:0]                  rtl_inc;
		dir_t                        first;
		logic [1:0]                  held_count;
		logic [HELD_BYTES-1:0][7:0]  held;
	} dec_t;

	function automatic dir_t dir_of(input logic [20:0] cp);
		dir_t r;
		priority if (cp >= 21'h00590 && cp <= 21'h008FF) r = DIR_RTL;
		else if (cp >= 21'h0FB1D && cp <= 21'h0FDFF) r = DIR_RTL;
		else if (cp >= 21'h0FE70 && cp <= 21'h0FEFF) r = DIR_RTL;
		else if (cp >= 21'h10800 && cp <= 21'h1091F) r = DIR_RTL;
		else if (cp >= 21'h10A00 && cp <= 21'h10A7F) r = DIR_RTL;
		else if (cp >= 21'h10AC0 && cp <= 21'h10B7F) r = DIR_RTL;
		else if (cp >= 21'h10D00 && cp <= 21'h10D3F) r = DIR_RTL;
		else if (cp >= 21'h10E60 && cp <= 21'h10E7F) r = DIR_RTL;
		else if (cp >= 21'h10EC0 && cp <= 21'h10EFF) r = DIR_RTL;
		else if (cp >= 21'h1E800 && cp <= 21'h1E95F) r = DIR_RTL;
		else if (cp <= 21'h00040) r = DIR_NONE;
		else if (cp >= 21'h0005B && cp <= 21'h00060) r = DIR_NONE;
		else if (cp >= 21'h0007B && cp <= 21'h000BF) r = DIR_NONE;
		else if (cp >= 21'h02000 && cp <= 21'h0206F) r = DIR_NONE;
		else r = DIR_LTR;
		return r;
	endfunction

	// one decode step at the head of the window
	function automatic step_t decode_step(
		input logic [7:0] w0,
		input logic [7:0] w1,
		input logic [7:0] w2,
		input logic [7:0] w3,
		input logic [2:0] n,
		input logic       last
	);
		logic [2:0]  need;
		logic [20:0] cp;
		logic [20:0] min_cp;
		logic        ok;
		step_t       r;
		r.emit = 1'b0;
		r.dir  = DIR_NONE;
		r.drop = 3'd0;
		r.stop = 1'b0;
		cp     = '0;
		min_cp = '0;
		ok     = 1'b0;
		priority if (w0 < 8'h80) need = 3'd1;
		else if (w0 >= LEAD2_LO && w0 <= LEAD2_HI) need = 3'd2;
		else if (w0 >= LEAD3_LO && w0 <= LEAD3_HI) need = 3'd3;
		else if (w0 >= LEAD4_LO && w0 <= LEAD4_HI) need = 3'd4;
		else need = 3'd0;

		priority if (n == 3'd0) begin
			r.stop = 1'b1;
		end else if (need > n) begin
			// hold for more bytes, or a cut-off tail at the end
			r.stop = 1'b1;
			if (last) begin
				r.emit = 1'b1;
				r.dir  = DIR_LTR;
				r.drop = n;
			end
		end else if (need == 3'd0) begin
			r.emit = 1'b1;
			r.dir  = DIR_LTR;
			r.drop = 3'd1;
		end else if (need == 3'd1) begin
			r.emit = 1'b1;
			r.dir  = dir_of({13'd0, w0});
			r.drop = 3'd1;
		end else begin
			unique case (need)
				3'd2: begin
					ok     = (w1[7:6] == 2'b10);
					cp     = {10'd0, w0[4:0], w1[5:0]};
					min_cp = 21'h00080;
				end
				3'd3: begin
					ok     = (w1[7:6] == 2'b10) && (w2[7:6] == 2'b10);
					cp     = {5'd0, w0[3:0], w1[5:0], w2[5:0]};
					min_cp = 21'h00800;
				end
				default: begin
					ok     = (w1[7:6] == 2'b10) && (w2[7:6] == 2'b10) &&
						(w3[7:6] == 2'b10);
					cp     = {w0[2:0], w1[5:0], w2[5:0], w3[5:0]};
					min_cp = 21'h10000;
				end
			endcase
			if (cp < min_cp || (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX)
				ok = 1'b0;
			r.emit = 1'b1;
			if (ok) begin
				r.dir  = dir_of(cp);
				r.drop = need;
			end else begin
				r.dir  = DIR_LTR;
				r.drop = 3'd1;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/u8td_decode.sv =====
// u8td_decode: decodes the held bytes plus one new byte into direction counts
// depends on u8td_pkg (decode_step, dec_t)

module u8td_decode
	import u8td_pkg::*;
(
	input  logic [HELD_BYTES-1:0][7:0] held,
	input  logic [1:0]                 held_count,
	input  logic [7:0]                 data_byte,
	input  logic                       last,
	output dec_t                       dec
);

	always_comb begin
		logic [7:0] w  [WIN_BYTES];
		logic [7:0] wn [WIN_BYTES];
		logic [2:0] n;
		logic [2:0] src;
		logic       run;
		step_t      st;
		for (int k = 0; k < WIN_BYTES; k++) begin
			if (k < HELD_BYTES && 2'(k) < held_count)
				w[k] = held[k];
			else if (3'(k) == {1'b0, held_count})
				w[k] = data_byte;
			else
				w[k] = 8'h00;
			wn[k] = 8'h00;
		end
		n           = {1'b0, held_count} + 3'd1;
		run         = 1'b1;
		src         = '0;
		dec.ltr_inc = '0;
		dec.rtl_inc = '0;
		dec.first   = DIR_NONE;
		for (int i = 0; i < WIN_BYTES; i++) begin
			st = decode_step(w[0], w[1], w[2], w[3], n, last);
			if (run) begin
				if (st.emit) begin
					if (st.dir == DIR_LTR) dec.ltr_inc = dec.ltr_inc + 3'd1;
					if (st.dir == DIR_RTL) dec.rtl_inc = dec.rtl_inc + 3'd1;
					if (dec.first == DIR_NONE) dec.first = st.dir;
				end
				if (st.stop) run = 1'b0;
				for (int k = 0; k < WIN_BYTES; k++) begin
					src   = 3'(k) + st.drop;
					wn[k] = (src < 3'(WIN_BYTES)) ? w[src[1:0]] : 8'h00;
				end
				for (int k = 0; k < WIN_BYTES; k++) w[k] = wn[k];
				n = n - st.drop;
			end
		end
		dec.held_count = n[1:0];
		for (int k = 0; k < HELD_BYTES; k++) dec.held[k] = w[k];
	end

endmodule

// ===== rtl/core/utf8_text_direction_scan.sv =====
// utf8_text_direction_scan: utf-8 byte stream to strong text direction summary
// depends on u8td_pkg and u8td_decode
//
//  channel  | valid       | stall       | word                | when
//  ---------+-------------+-------------+---------------------+---------------------------
//  text     | text_valid  | text_stall  | text  (text_word_t) | one byte of the string
//  scan     | scan_valid  | scan_stall  | scan  (scan_word_t) | once, after the last byte
//
// one byte per cycle unless a last byte waits on a stalled result; a byte in the input
// register is decoded against the held bytes and tallies in that same cycle
// the result register loads at the edge the last byte leaves the input register
// reset clears held bytes, tallies and first direction, and empties both registers
// only a last byte waits on a stalled result; other bytes keep flowing

module utf8_text_direction_scan
	import u8td_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  text_word_t text,
	output logic       scan_valid,
	input  logic       scan_stall,
	output scan_word_t scan
);

	localparam logic [COUNT_BITS-1:0] TALLY_MAX = {COUNT_BITS{1'b1}};

	logic                       text_valid_s1;
	text_word_t                 text_s1;
	logic                       s1_go;

	logic [HELD_BYTES-1:0][7:0] held_q;
	logic [1:0]                 held_count_q;
	logic [COUNT_BITS-1:0]      ltr_tally_q;
	logic [COUNT_BITS-1:0]      rtl_tally_q;
	dir_t                       first_dir_q;

	logic                       res_valid_q;
	logic [COUNT_BITS-1:0]      res_ltr_q;
	logic [COUNT_BITS-1:0]      res_rtl_q;
	dir_t                       res_first_q;

	dec_t                       dec;
	logic [COUNT_BITS:0]        ltr_sum;
	logic [COUNT_BITS:0]        rtl_sum;
	logic [COUNT_BITS-1:0]      ltr_next;
	logic [COUNT_BITS-1:0]      rtl_next;
	dir_t                       first_next;

	u8td_decode u_decode (
		.held       (held_q),
		.held_count (held_count_q),
		.data_byte  (text_s1.data_byte),
		.last       (text_s1.end_of_string),
		.dec        (dec)
	);

	assign s1_go      = text_valid_s1 &&
		!(text_s1.end_of_string && res_valid_q && scan_stall);
	assign text_stall = text_valid_s1 && !s1_go;

	always_comb begin
		ltr_sum    = {1'b0, ltr_tally_q} + (COUNT_BITS+1)'(dec.ltr_inc);
		rtl_sum    = {1'b0, rtl_tally_q} + (COUNT_BITS+1)'(dec.rtl_inc);
		ltr_next   = ltr_sum[COUNT_BITS] ? TALLY_MAX : ltr_sum[COUNT_BITS-1:0];
		rtl_next   = rtl_sum[COUNT_BITS] ? TALLY_MAX : rtl_sum[COUNT_BITS-1:0];
		first_next = (first_dir_q == DIR_NONE) ? dec.first : first_dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_s1 <= 1'b0;
		end else if (!text_valid_s1 || s1_go) begin
			text_valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_valid_s1 || s1_go) begin
			text_s1 <= text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_count_q <= '0;
			ltr_tally_q  <= '0;
			rtl_tally_q  <= '0;
			first_dir_q  <= DIR_NONE;
		end else if (s1_go) begin
			if (text_s1.end_of_string) begin
				held_q       <= '0;
				held_count_q <= '0;
				ltr_tally_q  <= '0;
				rtl_tally_q  <= '0;
				first_dir_q  <= DIR_NONE;
			end else begin
				held_q       <= dec.held;
				held_count_q <= dec.held_count;
				ltr_tally_q  <= ltr_next;
				rtl_tally_q  <= rtl_next;
				first_dir_q  <= first_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && text_s1.end_of_string) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !scan_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && text_s1.end_of_string) begin
			res_ltr_q   <= ltr_next;
			res_rtl_q   <= rtl_next;
			res_first_q <= first_next;
		end
	end

	always_comb begin
		if (res_ltr_q != '0 && res_rtl_q != '0)
			scan.overall_direction = OVR_MIXED;
		else if (res_rtl_q != '0)
			scan.overall_direction = OVR_RTL;
		else
			scan.overall_direction = OVR_LTR;
		scan.first_strong_dir = res_first_q;
		scan.rtl_majority     = (res_rtl_q > res_ltr_q);
		scan.ltr_majority     = (res_ltr_q >= res_rtl_q);
		scan.ltr_total        = TOTAL_BITS'(res_ltr_q);
		scan.rtl_total        = TOTAL_BITS'(res_rtl_q);
	end

	assign scan_valid = res_valid_q;

	// a held sequence always starts with a multi-byte lead
	a_held_lead: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd0 |-> (held_q[0] >= LEAD2_LO && held_q[0] <= LEAD4_HI))
		else $error("held sequence without a valid lead");

	// last byte produces a result and clears the string state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && text_s1.end_of_string |=>
			res_valid_q && held_count_q == 2'd0 && ltr_tally_q == '0 &&
			rtl_tally_q == '0 && first_dir_q == DIR_NONE)
		else $error("end of string did not yield a result and clear state");

	// an empty input register never stalls the source
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!text_valid_s1 |-> !text_stall)
		else $error("stall while input register empty");

	// tallies only grow within a string
	a_tally_grows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !text_s1.end_of_string |=>
			ltr_tally_q >= $past(ltr_tally_q) && rtl_tally_q >= $past(rtl_tally_q))
		else $error("tally decreased inside a string");

endmodule
